FILE: hw/rtl/mexp_pkg.sv
package mexp_pkg;

  // Base field width, scanned MSB first during the initial reduction
  localparam int BASE_W = 63;
  // Step counter width, holds up to BASE_W
  localparam int CNT_W  = 6;
  // Result field width on the output channel
  localparam int OUT_W  = 32;

  // Request into the shared modular multiply unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mm_ctrl_t;

  // Status back from the unit
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

FILE: hw/rtl/mexp_in_if.sv
interface mexp_in_if #(
  parameter int EXP_W = 64
);
  import mexp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic [EXP_W-1:0]  exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);

endinterface

FILE: hw/rtl/mexp_out_if.sv
interface mexp_out_if;
  import mexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);

endinterface

FILE: hw/rtl/mexp_mulmod.sv
// Bit-serial modular multiply: one multiplier bit per cycle, MSB first.
// Each step forms r = (2r + bit*mcand) mod m with mcand <= m, so the
// sum stays below 3m and one of two subtractions brings it back.
module mexp_mulmod #(
  parameter int MW = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mexp_pkg::mm_ctrl_t          ctrl,
  input  logic [MW-1:0]               mcand,
  input  logic [mexp_pkg::BASE_W-1:0] mplier,
  input  logic [MW-1:0]               modulus,
  output mexp_pkg::mm_stat_t          stat,
  output logic [MW-1:0]               result
);
  import mexp_pkg::*;

  logic [MW-1:0]     r_r, r_nxt;
  logic [MW-1:0]     a_r;
  logic [BASE_W-1:0] x_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [MW+1:0] sum, m1, m2, d1, d2;

  // Shift-add step with reduction against m and 2m in parallel
  always_comb begin
    sum = {1'b0, r_r, 1'b0} + (x_r[BASE_W-1] ? {2'b00, a_r} : '0);
    m1  = {2'b00, modulus};
    m2  = {1'b0, modulus, 1'b0};
    d1  = sum - m1;
    d2  = sum - m2;
    priority if (sum >= m2) begin
      r_nxt = d2[MW-1:0];
    end else if (sum >= m1) begin
      r_nxt = d1[MW-1:0];
    end else begin
      r_nxt = sum[MW-1:0];
    end
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      r_r   <= '0;
      a_r   <= mcand;
      x_r   <= mplier;
      cnt_r <= ctrl.nbits;
    end else if (busy_r) begin
      r_r   <= r_nxt;
      x_r   <= x_r << 1;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = r_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiply unit flags done while still busy");

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && modulus != '0 |-> r_r < modulus)
    else $error("multiply unit result not reduced");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> busy_r)
    else $error("multiply unit did not go busy on start");

endmodule

FILE: hw/rtl/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply on one shared
// bit-serial multiply unit. A zero exponent or a zero modulus skips the
// unit. One request at a time; the unit's step loop sets the rate. Reset
// idles the sequencer, empties the output, modulus 1000000007.
module modular_exponentiation #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [31:0]              cfg_wdata,
  mexp_in_if.sink                  in_ch,
  mexp_out_if.source               out_ch
);
  import mexp_pkg::*;

  localparam logic [31:0] MOD_RESET = 32'd1000000007;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_STEP = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [31:0]            mod_r;
  logic [EXP_WIDTH-1:0]   e_r, e_nxt;
  logic [MOD_WIDTH-1:0]   b_r, b_nxt;
  logic [MOD_WIDTH-1:0]   acc_r, acc_nxt;
  logic [MOD_WIDTH-1:0]   res_r, res_nxt;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_data_r;
  logic                   out_load;

  logic [MOD_WIDTH-1:0]   m;
  mm_ctrl_t               mm_ctrl;
  mm_stat_t               mm_stat;
  logic [MOD_WIDTH-1:0]   mm_mcand;
  logic [BASE_W-1:0]      mm_mplier;
  logic [MOD_WIDTH-1:0]   mm_result;

  assign m = mod_r[MOD_WIDTH-1:0];

  // Shared multiply unit
  mexp_mulmod #(.MW(MOD_WIDTH)) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mm_ctrl),
    .mcand   (mm_mcand),
    .mplier  (mm_mplier),
    .modulus (m),
    .stat    (mm_stat),
    .result  (mm_result)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    mm_ctrl.start = 1'b0;
    mm_ctrl.nbits = CNT_W'(MOD_WIDTH);
    mm_mcand      = b_r;
    mm_mplier     = {b_r, {(BASE_W-MOD_WIDTH){1'b0}}};
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          e_nxt = in_ch.exponent;
          if (in_ch.exponent == '0) begin
            res_nxt   = MOD_WIDTH'(1);
            state_nxt = S_DONE;
          end else if (m == '0) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // reduce the base: r = 2r + bit over all base bits
            mm_ctrl.start = 1'b1;
            mm_ctrl.nbits = CNT_W'(BASE_W);
            mm_mcand      = MOD_WIDTH'(1);
            mm_mplier     = in_ch.base;
            state_nxt     = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_stat.done) begin
          b_nxt     = mm_result;
          acc_nxt   = MOD_WIDTH'(1);
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        mm_ctrl.start = 1'b1;
        if (e_r[0]) begin
          mm_mplier = {acc_r, {(BASE_W-MOD_WIDTH){1'b0}}};
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          acc_nxt = mm_result;
          if ((e_r >> 1) == '0) begin
            // last set bit: the further square is never used
            res_nxt   = mm_result;
            state_nxt = S_DONE;
          end else begin
            mm_ctrl.start = 1'b1;
            state_nxt     = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_stat.done) begin
          b_nxt     = mm_result;
          e_nxt     = e_r >> 1;
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= OUT_W'(res_r);
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.power_mod = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("request taken but sequencer stayed idle");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mm_ctrl.start |-> !mm_stat.busy)
    else $error("multiply started while unit busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.power_mod))
    else $error("waiting result dropped or changed");

endmodule

FILE: sim/modular_exponentiation_tb.sv
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  localparam int EXP_W       = 64;
  localparam int STALL_LIMIT = 40000;
  localparam bit [31:0] RESET_MODULUS = 32'd1000000007;

  // One outstanding request and the result it should produce
  typedef struct {
    bit [BASE_W-1:0] base;
    bit [EXP_W-1:0]  exponent;
    bit [OUT_W-1:0]  power_mod;
  } power_req_t;

  // Scoreboard: keeps its own copy of the modulus and the expected results
  class power_ledger;
    bit [31:0]  modulus;
    power_req_t pending_q[$];
    int         errors;
    int         requests;
    int         results;

    function new();
      modulus  = RESET_MODULUS;
      errors   = 0;
      requests = 0;
      results  = 0;
    endfunction

    function void set_modulus(bit [31:0] value);
      modulus = value;
    endfunction

    // Right-to-left square-and-multiply, products exact in 64 bits
    function bit [OUT_W-1:0] predict_power(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e);
      bit [63:0]      m;
      bit [63:0]      acc;
      bit [63:0]      pw;
      bit [EXP_W-1:0] ex;
      m = {32'd0, modulus};
      if (e == '0) return 32'd1;
      if (m == 64'd0) return 32'd0;
      pw  = {1'b0, b} % m;
      acc = 64'd1;
      ex  = e;
      while (ex != '0) begin
        if (ex[0]) acc = (acc * pw) % m;
        ex = ex >> 1;
        pw = (pw * pw) % m;
      end
      return acc[OUT_W-1:0];
    endfunction

    function void note_request(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e);
      power_req_t req;
      req.base      = b;
      req.exponent  = e;
      req.power_mod = predict_power(b, e);
      pending_q     = {pending_q, req};
      requests++;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task check_result(bit [OUT_W-1:0] got);
      power_req_t want;
      results++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = pending_q[0];
      pending_q.delete(0);
      if (got !== want.power_mod)
        report_mismatch($sformatf("base %h exp %h mod %h: power_mod %h, want %h",
                                  want.base, want.exponent, modulus, got, want.power_mod));
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = 32'd0;
  bit          calm      = 1'b0;
  int          stall_cycles = 0;
  int          settings  = 1;

  power_ledger ledger = new();

  mexp_in_if #(.EXP_W(EXP_W)) in_ch ();
  mexp_out_if                 out_ch ();

  modular_exponentiation #(
    .MOD_WIDTH(32),
    .EXP_WIDTH(EXP_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.base     = '0;
    in_ch.exponent = '0;
    out_ch.ready   = 1'b0;
  end

  // Random idle with a chance of about 8 in a hundred per call, none while calm
  function automatic bit take_break();
    return !calm && ($urandom_range(99, 0) < 8);
  endfunction

  // Result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= rst_n && !take_break();
  end

  // Result checking and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) ledger.check_result(out_ch.power_mod);
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: nothing moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one request; entered and left at a falling edge
  task automatic send_request(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.base     <= b;
    in_ch.exponent <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.note_request(b, e);
    @(negedge clk);
  endtask

  // Stop requesting and wait for every outstanding result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (ledger.pending_q.size() != 0) @(negedge clk);
  endtask

  // Modulus write, only with the block idle
  task automatic write_modulus(bit [31:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.set_modulus(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Random requests with edge values mixed in
  task automatic send_random(int count);
    bit [63:0]       r;
    bit [63:0]       mult;
    bit [BASE_W-1:0] b;
    bit [EXP_W-1:0]  e;
    int              width;
    repeat (count) begin
      r = {$urandom(), $urandom()};
      case ($urandom_range(7, 0))
        0: b = '0;
        1: b = '1;
        2: begin
          mult = {32'd0, ledger.modulus} * 64'($urandom_range(3, 0));
          b = mult[BASE_W-1:0];
        end
        default: b = r[BASE_W-1:0];
      endcase
      r = {$urandom(), $urandom()};
      case ($urandom_range(9, 0))
        0: e = '0;
        1: e = '1;
        2, 3, 4, 5: begin
          width = $urandom_range(EXP_W, 1);
          e = r;
          if (width < EXP_W) e = r & ((64'd1 << width) - 64'd1);
        end
        default: e = r;
      endcase
      send_request(b, e);
    end
  endtask

  // Stimulus
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset modulus: edges of both fields and a few known results
    send_request(63'd0, 64'd0);
    send_request(63'd0, 64'd5);
    send_request('1, 64'd0);
    send_request('1, '1);
    send_request(63'd2, 64'd1);
    send_request(63'd2, 64'd10);
    send_request(63'd1000000007, 64'd3);
    send_request(63'd1000000006, 64'd2);
    send_request(63'd3, 64'h8000_0000_0000_0000);
    send_request('1, 64'd1);
    send_request(63'd12345, 64'd1000000006);
    send_random(20);

    // Largest modulus
    write_modulus(32'hFFFF_FFFF);
    send_request('1, '1);
    send_request(63'h0_FFFF_FFFE, 64'd2);
    send_request(63'h0_FFFF_FFFF, 64'd1);
    send_request(63'd0, 64'd0);
    send_random(25);

    // Modulus of one: zero exponent still gives 1
    write_modulus(32'd1);
    send_request(63'd5, 64'd0);
    send_request(63'd7, 64'd1);
    send_request('1, '1);
    send_random(10);

    // Modulus of zero: 1 for zero exponent, else 0
    write_modulus(32'd0);
    send_request(63'd5, 64'd0);
    send_request(63'd7, 64'd3);
    send_request('1, '1);
    send_random(10);

    // Smallest useful modulus
    write_modulus(32'd2);
    send_request(63'd3, '1);
    send_request(63'd4, 64'd1);
    send_random(15);

    // Random modulus, the first stretch with no idling on either side
    write_modulus($urandom() | 32'd1);
    calm = 1'b1;
    send_random(20);
    calm = 1'b0;
    send_random(20);

    drain_results();
    repeat (50) @(negedge clk);
    if (ledger.pending_q.size() != 0)
      ledger.report_mismatch($sformatf("%0d results never arrived", ledger.pending_q.size()));

    $display("Run covered %0d requests and %0d results over %0d modulus settings,",
             ledger.requests, ledger.results, settings);
    $display("among them moduli 0, 1, 2 and 2^32-1 with zero and all-ones exponents.");
    if (ledger.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
